// ----- rtl/core/ssr_pkg.sv -----
package ssr_pkg;

  localparam int unsigned DefCapacity    = 1024;
  localparam int unsigned DefHandleWidth = 32;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_PRESENT = 3'd1,
    STATUS_ABSENT  = 3'd2,
    STATUS_INVALID = 3'd3,
    STATUS_FULL    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_REM2,
    ST_CLEAR,
    ST_CLR_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic ready;     // input side may take an item
    logic accept;    // item taken this cycle
    logic commit;    // apply the lookup result, load output
    logic rem_fin;   // second map write of a remove
    logic sweep;     // clear one map entry
    logic clr_resp;  // finish a clear, load output
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_clear;    // incoming item is a clear
    logic need_rem2;   // the pending remove needs its second map write
    logic sweep_last;  // sweep is at the last map entry
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

// ----- rtl/core/sparse_set_swap_remove_table.sv -----
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_ready_o mode_i, handle_i, object_index_i
// out      output     out_valid_o/out_ready_i position_o, status_o, live_count_o
//
// Add, find and invalid-index items pass through the registered map and dense
// reads, then a commit; a remove needs a second write on the single map write
// port. A clear sweeps over the map memory, one entry a cycle, then gives its
// result. After reset the same sweep runs with in_ready_o low.
// A result waits in the output register; the next item is taken meanwhile and
// holds in its commit cycle until that register is free.
module sparse_set_swap_remove_table #(
  parameter int unsigned CAPACITY     = ssr_pkg::DefCapacity,
  parameter int unsigned HANDLE_WIDTH = ssr_pkg::DefHandleWidth,
  localparam int unsigned IW = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              mode_i,
  input  logic [HANDLE_WIDTH-1:0] handle_i,
  input  logic [IW-1:0]           object_index_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IW-1:0]           position_o,
  output logic [2:0]              status_o,
  output logic [IW-1:0]           live_count_o
);
  import ssr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ssr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssr_datapath #(
    .CAPACITY     (CAPACITY),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .handle_i       (handle_i),
    .object_index_i (object_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .position_o     (position_o),
    .status_o       (status_o),
    .live_count_o   (live_count_o)
  );

  assign in_ready_o = cmd.ready;

endmodule

// ----- rtl/core/ssr_ctrl.sv -----
module ssr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  ssr_pkg::sts_t sts_i,
  output ssr_pkg::cmd_t cmd_o
);
  import ssr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.in_clear ? ST_CLEAR : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.need_rem2 ? ST_REM2 : ST_IDLE;
        end
      end
      ST_REM2: begin
        cmd_o.rem_fin = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = ST_CLR_RESP;
      end
      ST_CLR_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.clr_resp = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

endmodule

// ----- rtl/core/ssr_datapath.sv -----
module ssr_datapath #(
  parameter int unsigned CAPACITY     = ssr_pkg::DefCapacity,
  parameter int unsigned HANDLE_WIDTH = ssr_pkg::DefHandleWidth,
  localparam int unsigned IW = $clog2(CAPACITY + 1),
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssr_pkg::cmd_t           cmd_i,
  output ssr_pkg::sts_t           sts_o,
  input  logic [1:0]              mode_i,
  input  logic [HANDLE_WIDTH-1:0] handle_i,
  input  logic [IW-1:0]           object_index_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IW-1:0]           position_o,
  output logic [2:0]              status_o,
  output logic [IW-1:0]           live_count_o
);
  import ssr_pkg::*;

  localparam logic [IW-1:0] CapI     = IW'(CAPACITY);
  localparam logic [AW-1:0] LastSlot = AW'(CAPACITY - 1);
  localparam int unsigned   DW       = HANDLE_WIDTH + AW;

  // map entry: {valid, slot}; dense entry: {handle, object index}
  logic [AW:0]   map_mem   [CAPACITY];
  logic [DW-1:0] dense_mem [CAPACITY];

  logic [AW:0]   map_rd_q;
  logic [DW-1:0] dense_rd_q;

  mode_e                   mode_q;
  logic [HANDLE_WIDTH-1:0] handle_q;
  logic [IW-1:0]           obj_q;
  logic [IW-1:0]           count_q, count_d;
  logic [AW-1:0]           sweep_q;

  logic                    out_valid_q;
  logic [IW-1:0]           pos_q;
  status_e                 status_q;
  logic [IW-1:0]           live_q;

  logic [IW-1:0] count_m1;
  logic          obj_bad, hit, full, cnt_zero;
  logic [AW-1:0] slot, last_obj;
  logic          do_add, do_rem;
  logic [IW-1:0] res_pos;
  status_e       res_status;

  logic          map_we, dense_we;
  logic [AW-1:0] map_wa, dense_wa;
  logic [AW:0]   map_wd;
  logic [DW-1:0] dense_wd;

  assign count_m1 = count_q - 1'b1;
  assign obj_bad  = (obj_q >= CapI);
  assign hit      = map_rd_q[AW];
  assign slot     = map_rd_q[AW-1:0];
  assign last_obj = dense_rd_q[AW-1:0];
  assign full     = (count_q >= CapI);
  assign cnt_zero = (count_q == '0);

  always_comb begin
    do_add     = 1'b0;
    do_rem     = 1'b0;
    res_pos    = CapI;
    res_status = STATUS_OK;
    count_d    = count_q;
    if (mode_q != MODE_CLEAR && obj_bad) begin
      res_status = STATUS_INVALID;
    end else begin
      unique case (mode_q)
        MODE_ADD: begin
          if (hit) begin
            res_pos    = IW'(slot);
            res_status = STATUS_PRESENT;
          end else if (full) begin
            res_status = STATUS_FULL;
          end else begin
            do_add  = 1'b1;
            res_pos = count_q;
            count_d = count_q + 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (!hit || cnt_zero) begin
            res_status = STATUS_ABSENT;
          end else begin
            do_rem  = 1'b1;
            res_pos = IW'(slot);
            count_d = count_m1;
          end
        end
        MODE_FIND: begin
          if (hit) res_pos = IW'(slot);
          else     res_status = STATUS_ABSENT;
        end
        MODE_CLEAR: ;
        default: ;
      endcase
    end
  end

  // write port selection
  always_comb begin
    map_we   = 1'b0;
    map_wa   = sweep_q;
    map_wd   = '0;
    dense_we = 1'b0;
    dense_wa = count_q[AW-1:0];
    dense_wd = {handle_q, obj_q[AW-1:0]};
    priority if (cmd_i.sweep) begin
      map_we = 1'b1;
    end else if (cmd_i.rem_fin) begin
      map_we = 1'b1;
      map_wa = obj_q[AW-1:0];
    end else if (cmd_i.commit && do_add) begin
      map_we   = 1'b1;
      map_wa   = obj_q[AW-1:0];
      map_wd   = {1'b1, count_q[AW-1:0]};
      dense_we = 1'b1;
    end else if (cmd_i.commit && do_rem) begin
      // last entry moves into the freed slot
      map_we   = 1'b1;
      map_wa   = last_obj;
      map_wd   = {1'b1, slot};
      dense_we = 1'b1;
      dense_wa = slot;
      dense_wd = dense_rd_q;
    end else begin
      map_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd_i.accept) map_rd_q <= map_mem[object_index_i[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (dense_we) dense_mem[dense_wa] <= dense_wd;
    if (cmd_i.accept) dense_rd_q <= dense_mem[count_m1[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= mode_e'(mode_i);
      handle_q <= handle_i;
      obj_q    <= object_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sweep_q <= '0;
    end else begin
      if (cmd_i.commit)        count_q <= count_d;
      else if (cmd_i.clr_resp) count_q <= '0;
      if (cmd_i.sweep) sweep_q <= (sweep_q == LastSlot) ? '0 : sweep_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit || cmd_i.clr_resp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pos_q    <= res_pos;
      status_q <= res_status;
      live_q   <= count_d;
    end else if (cmd_i.clr_resp) begin
      pos_q    <= CapI;
      status_q <= STATUS_OK;
      live_q   <= '0;
    end
  end

  assign sts_o.in_clear   = (mode_e'(mode_i) == MODE_CLEAR);
  assign sts_o.need_rem2  = do_rem;
  assign sts_o.sweep_last = (sweep_q == LastSlot);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign position_o   = pos_q;
  assign status_o     = status_q;
  assign live_count_o = live_q;

endmodule

// ----- tb/sv/tb_sparse_set_swap_remove_table.sv -----
`timescale 1ns / 100ps

module tb_sparse_set_swap_remove_table;
  import ssr_pkg::*;

  localparam int unsigned CAP        = DefCapacity;
  localparam int unsigned HW         = DefHandleWidth;
  localparam int unsigned IW         = $clog2(CAP + 1);
  localparam int unsigned IDLE_PCT   = 17;
  localparam int unsigned STALL_LIMIT = 10000;
  localparam int unsigned MAX_PRINTS = 100;

  typedef struct {
    logic [IW-1:0] pos;
    status_e       st;
    logic [IW-1:0] cnt;
  } table_result_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [1:0]    mode_i;
  logic [HW-1:0] handle_i;
  logic [IW-1:0] object_index_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [IW-1:0] position_o;
  logic [2:0]    status_o;
  logic [IW-1:0] live_count_o;

  // shadow copy of the table
  bit            obj_live   [CAP];
  logic [9:0]    obj_slot   [CAP];
  logic [HW-1:0] slot_handle[CAP];
  logic [9:0]    slot_owner [CAP];
  int unsigned   live_total;
  int unsigned   peak_total;

  table_result_t pending_results[$];
  bit            steady_flow;
  int unsigned   fail_count;
  int unsigned   items_sent;
  int unsigned   results_seen;
  int unsigned   status_tally[8];

  // handle of the item being predicted; the table keeps it only on an add
  logic [HW-1:0] handle_i_next;

  sparse_set_swap_remove_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .handle_i      (handle_i),
    .object_index_i(object_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .position_o    (position_o),
    .status_o      (status_o),
    .live_count_o  (live_count_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic table_result_t predict_table_op(input mode_e m, input logic [IW-1:0] obj);
    table_result_t r;
    int unsigned   freed;
    int unsigned   last;
    int unsigned   last_obj;
    r.pos = IW'(CAP);
    r.st  = STATUS_OK;
    if (m == MODE_CLEAR) begin
      foreach (obj_live[i]) obj_live[i] = 1'b0;
      live_total = 0;
    end else if (obj >= CAP) begin
      r.st = STATUS_INVALID;
    end else if (m == MODE_ADD) begin
      if (obj_live[obj]) begin
        r.pos = IW'(obj_slot[obj]);
        r.st  = STATUS_PRESENT;
      end else if (live_total >= CAP) begin
        r.st = STATUS_FULL;
      end else begin
        slot_handle[live_total] = handle_i_next;
        slot_owner[live_total]  = obj[9:0];
        obj_slot[obj]           = live_total[9:0];
        obj_live[obj]           = 1'b1;
        r.pos                   = IW'(live_total);
        live_total++;
      end
    end else if (m == MODE_REMOVE) begin
      if (!obj_live[obj] || live_total == 0) begin
        r.st = STATUS_ABSENT;
      end else begin
        // swap-remove: last entry drops into the freed slot
        freed              = obj_slot[obj];
        last               = live_total - 1;
        last_obj           = slot_owner[last];
        slot_handle[freed] = slot_handle[last];
        slot_owner[freed]  = last_obj[9:0];
        obj_slot[last_obj] = freed[9:0];
        obj_live[obj]      = 1'b0;
        live_total         = last;
        r.pos              = IW'(freed);
      end
    end else begin
      if (obj_live[obj]) r.pos = IW'(obj_slot[obj]);
      else r.st = STATUS_ABSENT;
    end
    if (live_total > peak_total) peak_total = live_total;
    r.cnt = IW'(live_total);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic send_item(input mode_e m, input logic [HW-1:0] h, input logic [IW-1:0] obj);
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    handle_i       <= h;
    object_index_i <= obj;
    do @(posedge clk_i); while (!in_ready_o);
    handle_i_next = h;
    pending_results.push_back(predict_table_op(m, obj));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_directed_cases();
    send_item(MODE_FIND, $urandom, 11'd5);
    send_item(MODE_REMOVE, $urandom, 11'd5);
    send_item(MODE_ADD, 32'h0000_0000, 11'd0);
    send_item(MODE_ADD, 32'hFFFF_FFFF, 11'd1023);
    send_item(MODE_ADD, $urandom, 11'd0);
    send_item(MODE_FIND, $urandom, 11'd1023);
    send_item(MODE_ADD, $urandom, 11'd1024);
    send_item(MODE_REMOVE, $urandom, 11'd2047);
    send_item(MODE_FIND, 32'hFFFF_FFFF, 11'd1024);
    send_item(MODE_ADD, 32'hA5A5_5A5A, 11'd512);
    // removing the first entry pulls the last one down to slot 0
    send_item(MODE_REMOVE, $urandom, 11'd0);
    send_item(MODE_FIND, $urandom, 11'd512);
    send_item(MODE_FIND, $urandom, 11'd0);
    // removing the last entry moves it onto itself
    send_item(MODE_REMOVE, $urandom, 11'd1023);
    send_item(MODE_REMOVE, $urandom, 11'd1023);
    send_item(MODE_CLEAR, $urandom, 11'd2047);
    send_item(MODE_FIND, $urandom, 11'd512);
    send_item(MODE_REMOVE, $urandom, 11'd512);
    send_item(MODE_ADD, $urandom, 11'd512);
    send_item(MODE_CLEAR, 32'h0, 11'd0);
  endtask

  task automatic test_random_churn(input int unsigned n_items);
    int unsigned pool;
    int unsigned roll;
    pool = 4;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n % 50 == 0) begin
        roll = $urandom_range(0, 2);
        pool = (roll == 0) ? 4 : (roll == 1) ? 16 : 64;
      end
      if (n == n_items / 2) wait_for_drain();
      roll = $urandom_range(0, 99);
      if (roll < 40)
        send_item(MODE_ADD, $urandom, IW'($urandom_range(0, pool - 1)));
      else if (roll < 70)
        send_item(MODE_REMOVE, $urandom, IW'($urandom_range(0, pool - 1)));
      else if (roll < 90)
        send_item(MODE_FIND, $urandom, IW'($urandom_range(0, pool - 1)));
      else if (roll < 92)
        send_item(MODE_CLEAR, $urandom, IW'($urandom_range(0, 2047)));
      else
        send_item(mode_e'($urandom_range(0, 2)), $urandom, IW'($urandom_range(CAP, 2047)));
    end
  endtask

  // every index owns one slot, so a full table has every index present
  task automatic test_fill_to_capacity();
    int unsigned order[CAP];
    int unsigned j;
    int unsigned tmp;
    foreach (order[i]) order[i] = i;
    for (int unsigned i = CAP - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_item(MODE_CLEAR, $urandom, 11'd0);
    steady_flow = 1'b1;
    for (int unsigned k = 0; k < CAP; k++) begin
      if (k == 300) steady_flow = 1'b0;
      send_item(MODE_ADD, $urandom, IW'(order[k]));
      if ($urandom_range(0, 99) < 2)
        send_item(MODE_FIND, $urandom, IW'(order[$urandom_range(0, k)]));
    end
    for (int unsigned k = 0; k < 4; k++)
      send_item(MODE_ADD, $urandom, IW'($urandom_range(0, CAP - 1)));
    send_item(MODE_FIND, $urandom, IW'(order[CAP - 1]));
    for (int unsigned k = 0; k < 10; k++)
      send_item(MODE_REMOVE, $urandom, IW'($urandom_range(0, CAP - 1)));
    for (int unsigned k = 0; k < 10; k++)
      send_item(MODE_ADD, $urandom, IW'($urandom_range(0, CAP - 1)));
    send_item(MODE_CLEAR, $urandom, 11'd1023);
  endtask

  always @(negedge clk_i)
    out_ready_i <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      status_tally[status_o]++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending, position", position_o, CAP);
      end else begin
        want = pending_results.pop_front();
        if (position_o !== want.pos) report_mismatch("position", position_o, want.pos);
        if (status_o !== want.st) report_mismatch("status", status_o, want.st);
        if (live_count_o !== want.cnt) report_mismatch("live_count", live_count_o, want.cnt);
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_FIND;
    handle_i       = '0;
    object_index_i = '0;
    steady_flow    = 1'b0;
    fail_count     = 0;
    items_sent     = 0;
    results_seen   = 0;
    live_total     = 0;
    peak_total     = 0;
    foreach (obj_live[i]) obj_live[i] = 1'b0;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_churn(60);
    test_fill_to_capacity();

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("items left without a result", pending_results.size(), 0);

    $display("Sent %0d items (add, remove, find, clear, bad index), checked %0d results,",
             items_sent, results_seen);
    $display("peak %0d of %0d entries; statuses ok %0d, present %0d, absent %0d, invalid %0d.",
             peak_total, CAP, status_tally[STATUS_OK], status_tally[STATUS_PRESENT],
             status_tally[STATUS_ABSENT], status_tally[STATUS_INVALID]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
